FILE: rtl/mic_pkg.sv
// Shared types, opcodes and constants for the integer execute core.
package mic_pkg;

  localparam int COP0_REGS_DEF = 32;

  localparam logic [31:0] STATUS_RESET = 32'h1090_0000;
  localparam logic [31:0] PRID_RESET   = 32'h0000_0002;
  localparam logic [31:0] PC_RESET     = 32'hbfc0_0000;
  localparam logic [31:0] EXC_VECTOR   = 32'h0000_0080;
  localparam logic [31:0] CAUSE_SYS    = 32'h0000_0020;
  localparam logic [31:0] CAUSE_SYS_BD = 32'h8000_0020;
  localparam logic [31:0] CAUSE_IRQ    = 32'h0000_0400;
  localparam logic [15:0] IRQ_IVL_RESET = 16'd128;

  localparam int C0_STATUS = 12;
  localparam int C0_CAUSE  = 13;
  localparam int C0_EPC    = 14;
  localparam int C0_PRID   = 15;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_COP0    = 6'd16;
  localparam logic [5:0] OP_LB      = 6'd32;
  localparam logic [5:0] OP_LH      = 6'd33;
  localparam logic [5:0] OP_LWL     = 6'd34;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_LBU     = 6'd36;
  localparam logic [5:0] OP_LHU     = 6'd37;
  localparam logic [5:0] OP_LWR     = 6'd38;
  localparam logic [5:0] OP_SB      = 6'd40;
  localparam logic [5:0] OP_SH      = 6'd41;
  localparam logic [5:0] OP_SWL     = 6'd42;
  localparam logic [5:0] OP_SW      = 6'd43;
  localparam logic [5:0] OP_SWR     = 6'd46;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL     = 6'd0;
  localparam logic [5:0] FN_SRL     = 6'd2;
  localparam logic [5:0] FN_SRA     = 6'd3;
  localparam logic [5:0] FN_SLLV    = 6'd4;
  localparam logic [5:0] FN_SRLV    = 6'd6;
  localparam logic [5:0] FN_SRAV    = 6'd7;
  localparam logic [5:0] FN_JR      = 6'd8;
  localparam logic [5:0] FN_JALR    = 6'd9;
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_MFHI    = 6'd16;
  localparam logic [5:0] FN_MTHI    = 6'd17;
  localparam logic [5:0] FN_MFLO    = 6'd18;
  localparam logic [5:0] FN_MTLO    = 6'd19;
  localparam logic [5:0] FN_MULT    = 6'd24;
  localparam logic [5:0] FN_MULTU   = 6'd25;
  localparam logic [5:0] FN_DIV     = 6'd26;
  localparam logic [5:0] FN_DIVU    = 6'd27;
  localparam logic [5:0] FN_ADD     = 6'd32;
  localparam logic [5:0] FN_ADDU    = 6'd33;
  localparam logic [5:0] FN_SUB     = 6'd34;
  localparam logic [5:0] FN_SUBU    = 6'd35;
  localparam logic [5:0] FN_AND     = 6'd36;
  localparam logic [5:0] FN_OR      = 6'd37;
  localparam logic [5:0] FN_XOR     = 6'd38;
  localparam logic [5:0] FN_NOR     = 6'd39;
  localparam logic [5:0] FN_SLT     = 6'd42;
  localparam logic [5:0] FN_SLTU    = 6'd43;
  localparam logic [5:0] FN_RFE     = 6'd16;

  localparam logic [4:0] RS_MFC0 = 5'd0;
  localparam logic [4:0] RS_MTC0 = 5'd4;
  localparam logic [4:0] RS_CO   = 5'd16;

  localparam logic [4:0] RT_BLTZ   = 5'd0;
  localparam logic [4:0] RT_BGEZ   = 5'd1;
  localparam logic [4:0] RT_BLTZAL = 5'd16;
  localparam logic [4:0] RT_BGEZAL = 5'd17;

  localparam logic [4:0] REG_LINK = 5'd31;

  // pending load kinds
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_LB   = 3'd1;
  localparam logic [2:0] KIND_LH   = 3'd2;
  localparam logic [2:0] KIND_LW   = 3'd3;
  localparam logic [2:0] KIND_LBU  = 3'd4;
  localparam logic [2:0] KIND_LHU  = 3'd5;
  localparam logic [2:0] KIND_LWL  = 3'd6;
  localparam logic [2:0] KIND_LWR  = 3'd7;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;

  // multiply/divide unit operations (low bits of the function code)
  localparam logic [1:0] MD_MULT  = 2'd0;
  localparam logic [1:0] MD_MULTU = 2'd1;
  localparam logic [1:0] MD_DIV   = 2'd2;
  localparam logic [1:0] MD_DIVU  = 2'd3;

  localparam logic SEL_MD  = 1'b0;
  localparam logic SEL_MOD = 1'b1;

  typedef struct packed {
    logic capture;
    logic commit;
    logic md_start;
    logic md_sel;
  } mic_cmd_t;

  typedef struct packed {
    logic md_req;
    logic mod_req;
    logic md_done;
  } mic_stat_t;

  function automatic logic [31:0] lwl_keep(input logic [1:0] off);
    case (off)
      2'd0:    lwl_keep = 32'h00ff_ffff;
      2'd1:    lwl_keep = 32'h0000_ffff;
      2'd2:    lwl_keep = 32'h0000_00ff;
      default: lwl_keep = 32'h0000_0000;
    endcase
  endfunction

  function automatic logic [31:0] lwr_keep(input logic [1:0] off);
    case (off)
      2'd0:    lwr_keep = 32'h0000_0000;
      2'd1:    lwr_keep = 32'hff00_0000;
      2'd2:    lwr_keep = 32'hffff_0000;
      default: lwr_keep = 32'hffff_ff00;
    endcase
  endfunction

endpackage

FILE: rtl/mic_ram.sv
// Generic RAM: one write port, two registered read ports.
module mic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: rtl/mic_mdu.sv
// Iterative multiply/divide unit, one bit per cycle.
module mic_mdu (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] hi,
  output logic [31:0] lo
);
  import mic_pkg::*;

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_RUN  = 2'd1;
  localparam logic [1:0] M_FIX  = 2'd2;

  logic [1:0]  state;
  logic [4:0]  cnt;
  logic        is_div;
  logic        neg_q;
  logic        neg_r;
  logic [31:0] m;
  logic        sgn;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [32:0] sum;
  logic [32:0] shifted;
  logic [33:0] diff;
  logic [63:0] prod_neg;

  always_comb begin
    sgn      = (op == MD_MULT) || (op == MD_DIV);
    ma       = (sgn && a[31]) ? -a : a;
    mb       = (sgn && b[31]) ? -b : b;
    sum      = {1'b0, hi} + (lo[0] ? {1'b0, m} : 33'd0);
    shifted  = {hi, lo[31]};
    diff     = {1'b0, shifted} - {2'b00, m};
    prod_neg = -{hi, lo};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (start) begin
            is_div <= op[1];
            m      <= op[1] ? mb : ma;
            hi     <= 32'd0;
            lo     <= op[1] ? ma : mb;
            neg_q  <= sgn && (a[31] ^ b[31]);
            neg_r  <= sgn && a[31];
            cnt    <= 5'd0;
            state  <= M_RUN;
          end
        end
        M_RUN: begin
          if (is_div) begin
            if (!diff[33]) begin
              hi <= diff[31:0];
              lo <= {lo[30:0], 1'b1};
            end else begin
              hi <= shifted[31:0];
              lo <= {lo[30:0], 1'b0};
            end
          end else begin
            hi <= sum[32:1];
            lo <= {sum[0], lo[31:1]};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= M_FIX;
          end
        end
        M_FIX: begin
          if (is_div) begin
            lo <= neg_q ? -lo : lo;
            hi <= neg_r ? -hi : hi;
          end else if (neg_q) begin
            {hi, lo} <= prod_neg;
          end
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/mic_dp.sv
// Datapath: architectural state, instruction decode/execute, load return.
module mic_dp #(
  parameter int COP0_REGS = mic_pkg::COP0_REGS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  mic_pkg::mic_cmd_t  cmd,
  output mic_pkg::mic_stat_t st,
  input  logic             mode,
  input  logic [31:0]      instr_word,
  input  logic [31:0]      load_data,
  input  logic             irq_pending,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_data,
  output logic [31:0]      fetch_addr,
  output logic [1:0]       mem_op,
  output logic [31:0]      mem_addr,
  output logic [3:0]       byte_enable,
  output logic [31:0]      store_data,
  output logic             awaiting_load,
  output logic             exception_taken
);
  import mic_pkg::*;

  localparam int CW = $clog2(COP0_REGS);
  localparam logic [CW-1:0] IX_STATUS = CW'(C0_STATUS);
  localparam logic [CW-1:0] IX_CAUSE  = CW'(C0_CAUSE);
  localparam logic [CW-1:0] IX_EPC    = CW'(C0_EPC);
  localparam logic [CW-1:0] IX_PRID   = CW'(C0_PRID);

  // captured item
  logic        mode_q;
  logic [31:0] instr_q;
  logic [31:0] ldata_q;
  logic        irq_q;

  logic [31:0] gpr_valid;
  logic [31:0] hi_reg;
  logic [31:0] lo_reg;
  logic [31:0] prog_counter;
  logic [31:0] cop0 [COP0_REGS];
  logic        delay_pending;
  logic [31:0] delay_target;
  logic [15:0] instr_count;
  logic [4:0]  load_dest;
  logic [2:0]  load_kind;
  logic [1:0]  load_offset;
  logic [15:0] irq_interval;

  logic        md_req;
  logic        mod_req;
  logic [31:0] md_a;
  logic [31:0] md_b;
  logic [1:0]  md_op;
  logic [15:0] mod_a;
  logic [15:0] mod_b;

  logic [31:0] rda;
  logic [31:0] rdb;
  logic        md_done;
  logic [31:0] md_hi;
  logic [31:0] md_lo;

  // decode
  logic [5:0]  op;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sa;
  logic [5:0]  fn;
  logic [4:0]  ra_addr;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] simm;
  logic [31:0] uimm;
  logic [31:0] ea;
  logic [1:0]  off;
  logic [31:0] pc4;
  logic [31:0] pc8;
  logic [31:0] btarget;
  logic [31:0] jtarget;
  logic [4:0]  shamt;
  logic        rd_ok;
  logic [31:0] c0_rdata;

  // execute results
  logic        gw_en;
  logic [4:0]  gw_addr;
  logic [31:0] gw_data;
  logic        nb;
  logic [31:0] nt;
  logic        sys;
  logic        hi_wr;
  logic        lo_wr;
  logic        md_go;
  logic        c0_wr;
  logic        rfe;
  logic        ld_go;
  logic [2:0]  ld_kind;
  logic        take;
  logic [1:0]  mo;
  logic [31:0] ma;
  logic [3:0]  be;
  logic [4:0]  be_wl;
  logic [31:0] sd;

  // load return
  logic [31:0] lbyte;
  logic [31:0] lhalf;
  logic [31:0] lval;
  logic        lwr_en;

  // sequencing
  logic [31:0] status_cur;
  logic [31:0] status_mid;
  logic [31:0] status_exc;
  logic [15:0] cnt1;
  logic [15:0] iv;
  logic        check;
  logic        irq_take;
  logic        exc;
  logic [31:0] cause;
  logic [31:0] epc;
  logic [31:0] pc_next;
  logic        dp_next;

  mic_ram #(
    .WIDTH(32),
    .DEPTH(32)
  ) u_gpr (
    .clk    (clk),
    .we     (cmd.commit && lwr_en),
    .waddr  (gw_addr),
    .wdata  (gw_data),
    .raddr_a(ra_addr),
    .raddr_b(rt),
    .rdata_a(rda),
    .rdata_b(rdb)
  );

  mic_mdu u_mdu (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.md_start),
    .op   ((cmd.md_sel == SEL_MOD) ? MD_DIVU : md_op),
    .a    ((cmd.md_sel == SEL_MOD) ? {16'd0, mod_a} : md_a),
    .b    ((cmd.md_sel == SEL_MOD) ? {16'd0, mod_b} : md_b),
    .done (md_done),
    .hi   (md_hi),
    .lo   (md_lo)
  );

  always_comb begin
    op      = instr_q[31:26];
    rs      = instr_q[25:21];
    rt      = instr_q[20:16];
    rd      = instr_q[15:11];
    sa      = instr_q[10:6];
    fn      = instr_q[5:0];
    ra_addr = mode_q ? load_dest : rs;
    a       = gpr_valid[ra_addr] ? rda : 32'd0;
    b       = gpr_valid[rt] ? rdb : 32'd0;
    simm    = {{16{instr_q[15]}}, instr_q[15:0]};
    uimm    = {16'd0, instr_q[15:0]};
    ea      = a + simm;
    off     = ea[1:0];
    pc4     = prog_counter + 32'd4;
    pc8     = prog_counter + 32'd8;
    btarget = pc4 + {simm[29:0], 2'b00};
    jtarget = {pc4[31:28], instr_q[25:0], 2'b00};
    shamt   = fn[2] ? a[4:0] : sa;
    rd_ok   = int'(rd) < COP0_REGS;
    c0_rdata = rd_ok ? cop0[rd[CW-1:0]] : 32'd0;
  end

  // instruction execute
  always_comb begin
    gw_en   = 1'b0;
    gw_addr = rd;
    gw_data = 32'd0;
    nb      = 1'b0;
    nt      = 32'd0;
    sys     = 1'b0;
    hi_wr   = 1'b0;
    lo_wr   = 1'b0;
    md_go   = 1'b0;
    c0_wr   = 1'b0;
    rfe     = 1'b0;
    ld_go   = 1'b0;
    ld_kind = KIND_NONE;
    take    = 1'b0;
    mo      = MEM_NONE;
    ma      = 32'd0;
    be      = 4'd0;
    be_wl   = 5'(5'd2 << off) - 5'd1;
    sd      = 32'd0;
    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_SLL, FN_SLLV: begin
            gw_en = 1'b1; gw_data = b << shamt;
          end
          FN_SRL, FN_SRLV: begin
            gw_en = 1'b1; gw_data = b >> shamt;
          end
          FN_SRA, FN_SRAV: begin
            gw_en = 1'b1; gw_data = $unsigned($signed(b) >>> shamt);
          end
          FN_JR: begin
            nb = 1'b1; nt = a;
          end
          FN_JALR: begin
            nb = 1'b1; nt = a; gw_en = 1'b1; gw_data = pc8;
          end
          FN_SYSCALL: sys = 1'b1;
          FN_MFHI: begin
            gw_en = 1'b1; gw_data = hi_reg;
          end
          FN_MTHI: hi_wr = 1'b1;
          FN_MFLO: begin
            gw_en = 1'b1; gw_data = lo_reg;
          end
          FN_MTLO: lo_wr = 1'b1;
          FN_MULT, FN_MULTU: md_go = 1'b1;
          FN_DIV, FN_DIVU: md_go = (b != 32'd0);
          FN_ADD, FN_ADDU: begin
            gw_en = 1'b1; gw_data = a + b;
          end
          FN_SUB, FN_SUBU: begin
            gw_en = 1'b1; gw_data = a - b;
          end
          FN_AND: begin
            gw_en = 1'b1; gw_data = a & b;
          end
          FN_OR: begin
            gw_en = 1'b1; gw_data = a | b;
          end
          FN_XOR: begin
            gw_en = 1'b1; gw_data = a ^ b;
          end
          FN_NOR: begin
            gw_en = 1'b1; gw_data = ~(a | b);
          end
          FN_SLT: begin
            gw_en = 1'b1; gw_data = {31'd0, $signed(a) < $signed(b)};
          end
          FN_SLTU: begin
            gw_en = 1'b1; gw_data = {31'd0, a < b};
          end
          default: begin
          end
        endcase
      end
      OP_REGIMM: begin
        if (rt == RT_BLTZ || rt == RT_BGEZ || rt == RT_BLTZAL || rt == RT_BGEZAL) begin
          take = rt[0] ? !a[31] : a[31];
          if (rt[4]) begin
            gw_en = 1'b1; gw_addr = REG_LINK; gw_data = pc8;
          end
          nb = take; nt = btarget;
        end
      end
      OP_J: begin
        nb = 1'b1; nt = jtarget;
      end
      OP_JAL: begin
        nb = 1'b1; nt = jtarget;
        gw_en = 1'b1; gw_addr = REG_LINK; gw_data = pc8;
      end
      OP_BEQ: begin
        nb = (a == b); nt = btarget;
      end
      OP_BNE: begin
        nb = (a != b); nt = btarget;
      end
      OP_BLEZ: begin
        nb = a[31] || (a == 32'd0); nt = btarget;
      end
      OP_BGTZ: begin
        nb = !a[31] && (a != 32'd0); nt = btarget;
      end
      OP_ADDI, OP_ADDIU: begin
        gw_en = 1'b1; gw_addr = rt; gw_data = ea;
      end
      OP_SLTI: begin
        gw_en = 1'b1; gw_addr = rt; gw_data = {31'd0, $signed(a) < $signed(simm)};
      end
      OP_SLTIU: begin
        gw_en = 1'b1; gw_addr = rt; gw_data = {31'd0, a < uimm};
      end
      OP_ANDI: begin
        gw_en = 1'b1; gw_addr = rt; gw_data = a & uimm;
      end
      OP_ORI: begin
        gw_en = 1'b1; gw_addr = rt; gw_data = a | uimm;
      end
      OP_XORI: begin
        gw_en = 1'b1; gw_addr = rt; gw_data = a ^ uimm;
      end
      OP_LUI: begin
        gw_en = 1'b1; gw_addr = rt; gw_data = {instr_q[15:0], 16'd0};
      end
      OP_COP0: begin
        if (rs == RS_MFC0) begin
          gw_en = 1'b1; gw_addr = rt; gw_data = c0_rdata;
        end else if (rs == RS_MTC0) begin
          c0_wr = rd_ok;
        end else if (rs == RS_CO && fn == FN_RFE) begin
          rfe = 1'b1;
        end
      end
      OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR: begin
        ld_go = 1'b1;
        case (op)
          OP_LB:   ld_kind = KIND_LB;
          OP_LH:   ld_kind = KIND_LH;
          OP_LWL:  ld_kind = KIND_LWL;
          OP_LW:   ld_kind = KIND_LW;
          OP_LBU:  ld_kind = KIND_LBU;
          OP_LHU:  ld_kind = KIND_LHU;
          default: ld_kind = KIND_LWR;
        endcase
        mo = MEM_READ;
        ma = (op == OP_LWL || op == OP_LWR) ? {ea[31:2], 2'b00} : ea;
      end
      OP_SB: begin
        mo = MEM_WRITE; ma = ea; be = 4'b0001 << off;
        sd = {24'd0, b[7:0]} << {off, 3'b000};
      end
      OP_SH: begin
        mo = MEM_WRITE; ma = ea; be = 4'b0011 << {off[1], 1'b0};
        sd = {16'd0, b[15:0]} << {off[1], 4'b0000};
      end
      OP_SWL: begin
        mo = MEM_WRITE; ma = {ea[31:2], 2'b00}; be = be_wl[3:0];
        sd = b >> {~off, 3'b000};
      end
      OP_SW: begin
        mo = MEM_WRITE; ma = ea; be = 4'b1111; sd = b;
      end
      OP_SWR: begin
        mo = MEM_WRITE; ma = {ea[31:2], 2'b00}; be = 4'b1111 << off;
        sd = b << {off, 3'b000};
      end
      default: begin
      end
    endcase

    // load return overrides the write port
    lbyte  = ldata_q >> {load_offset, 3'b000};
    lhalf  = ldata_q >> {load_offset[1], 4'b0000};
    case (load_kind)
      KIND_LB:  lval = {{24{lbyte[7]}}, lbyte[7:0]};
      KIND_LBU: lval = {24'd0, lbyte[7:0]};
      KIND_LH:  lval = {{16{lhalf[15]}}, lhalf[15:0]};
      KIND_LHU: lval = {16'd0, lhalf[15:0]};
      KIND_LW:  lval = ldata_q;
      KIND_LWL: lval = (a & lwl_keep(load_offset)) | (ldata_q << {~load_offset, 3'b000});
      KIND_LWR: lval = (a & lwr_keep(load_offset)) | (ldata_q >> {load_offset, 3'b000});
      default:  lval = 32'd0;
    endcase
    if (mode_q) begin
      gw_addr = load_dest;
      gw_data = lval;
      gw_en   = (load_kind != KIND_NONE);
    end
    lwr_en = gw_en && (gw_addr != 5'd0);
  end

  // exception, delay slot and interrupt check
  always_comb begin
    status_cur = cop0[IX_STATUS];
    if (c0_wr && rd[CW-1:0] == IX_STATUS) begin
      status_mid = b;
    end else if (rfe) begin
      status_mid = {status_cur[31:4], status_cur[5:2]};
    end else begin
      status_mid = status_cur;
    end
    status_exc = {status_mid[31:6], status_mid[3:0], 2'b00};
    cnt1     = instr_count + 16'd1;
    iv       = (irq_interval == 16'd0) ? 16'd1 : irq_interval;
    check    = !sys && delay_pending && (cnt1 >= iv);
    irq_take = check && irq_q && status_mid[0] && status_mid[10];
    exc      = sys || irq_take;
    if (sys) begin
      cause = delay_pending ? CAUSE_SYS_BD : CAUSE_SYS;
      epc   = delay_pending ? prog_counter - 32'd4 : prog_counter;
    end else begin
      cause = CAUSE_IRQ;
      epc   = delay_target;
    end
    if (exc) begin
      pc_next = EXC_VECTOR;
    end else if (delay_pending) begin
      pc_next = delay_target;
    end else begin
      pc_next = pc4;
    end
    dp_next = nb && !exc;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q  <= mode;
      instr_q <= instr_word;
      ldata_q <= load_data;
      irq_q   <= irq_pending;
    end
    if (cmd.commit && !mode_q) begin
      md_a  <= a;
      md_b  <= b;
      md_op <= fn[1:0];
      mod_a <= cnt1;
      mod_b <= iv;
      if (hi_wr) begin
        hi_reg <= a;
      end
      if (lo_wr) begin
        lo_reg <= a;
      end
      delay_target <= nt;
    end
    if (md_done && cmd.md_sel == SEL_MD) begin
      hi_reg <= md_hi;
      lo_reg <= md_lo;
    end
    if (rst) begin
      hi_reg <= 32'd0;
      lo_reg <= 32'd0;
    end
    if (cmd.commit) begin
      fetch_addr      <= mode_q ? prog_counter : pc_next;
      mem_op          <= mode_q ? MEM_NONE : mo;
      mem_addr        <= mode_q ? 32'd0 : ma;
      byte_enable     <= mode_q ? 4'd0 : be;
      store_data      <= mode_q ? 32'd0 : sd;
      awaiting_load   <= !mode_q && ld_go;
      exception_taken <= !mode_q && exc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gpr_valid     <= 32'd0;
      prog_counter  <= PC_RESET;
      for (int i = 0; i < COP0_REGS; i++) begin
        cop0[i] <= 32'd0;
      end
      cop0[IX_STATUS] <= STATUS_RESET;
      cop0[IX_PRID]   <= PRID_RESET;
      delay_pending <= 1'b0;
      instr_count   <= 16'd0;
      load_dest     <= 5'd0;
      load_kind     <= KIND_NONE;
      load_offset   <= 2'd0;
      irq_interval  <= IRQ_IVL_RESET;
      md_req        <= 1'b0;
      mod_req       <= 1'b0;
    end else begin
      if (cfg_we) begin
        irq_interval <= cfg_data;
      end
      if (cmd.commit && lwr_en) begin
        gpr_valid[gw_addr] <= 1'b1;
      end
      if (cmd.commit) begin
        load_kind <= KIND_NONE;
        if (!mode_q) begin
          if (ld_go) begin
            load_kind   <= ld_kind;
            load_dest   <= rt;
            load_offset <= off;
          end
          prog_counter  <= pc_next;
          delay_pending <= dp_next;
          instr_count   <= check ? cnt1 : cnt1;
          md_req        <= md_go;
          mod_req       <= check;
          if (c0_wr) begin
            cop0[rd[CW-1:0]] <= b;
          end
          if (rfe) begin
            cop0[IX_STATUS] <= status_mid;
          end
          if (exc) begin
            cop0[IX_STATUS] <= status_exc;
            cop0[IX_CAUSE]  <= cause;
            cop0[IX_EPC]    <= epc;
          end
        end
      end
      if (md_done) begin
        if (cmd.md_sel == SEL_MOD) begin
          instr_count <= md_hi[15:0];
          mod_req     <= 1'b0;
        end else begin
          md_req <= 1'b0;
        end
      end
    end
  end

  assign st.md_req  = md_req;
  assign st.mod_req = mod_req;
  assign st.md_done = md_done;

endmodule

FILE: rtl/mic_ctrl.sv
// Controller: item sequencing, output register valid, mul/div dispatch.
module mic_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output mic_pkg::mic_cmd_t  cmd,
  input  mic_pkg::mic_stat_t st
);
  import mic_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_READ     = 3'd1;
  localparam logic [2:0] S_EXEC     = 3'd2;
  localparam logic [2:0] S_POST     = 3'd3;
  localparam logic [2:0] S_MD_WAIT  = 3'd4;
  localparam logic [2:0] S_MOD_WAIT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       slot_free;

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next   = state;
    cmd.capture  = 1'b0;
    cmd.commit   = 1'b0;
    cmd.md_start = 1'b0;
    cmd.md_sel   = SEL_MD;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: state_next = S_EXEC;
      S_EXEC: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_POST;
        end
      end
      S_POST: begin
        if (st.md_req) begin
          cmd.md_start = 1'b1;
          state_next   = S_MD_WAIT;
        end else if (st.mod_req) begin
          cmd.md_start = 1'b1;
          cmd.md_sel   = SEL_MOD;
          state_next   = S_MOD_WAIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MD_WAIT: begin
        if (st.md_done) begin
          state_next = S_POST;
        end
      end
      S_MOD_WAIT: begin
        cmd.md_sel = SEL_MOD;
        if (st.md_done) begin
          state_next = S_POST;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    st.md_done |-> (state == S_MD_WAIT || state == S_MOD_WAIT))
    else $error("mul/div done outside a wait state");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item accepted while one is in flight");
  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");
`endif

endmodule

FILE: rtl/mips1_integer_execute_core.sv
// Top level of the integer execute core: controller plus datapath.
//
// Input channel (in_valid/in_stall): mode 0 items carry the instruction
// word fetched at the last fetch_addr; mode 1 items return the word for a
// pending load. Output channel (out_valid/out_stall): one result per item
// with the next fetch address and any memory access the item makes.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes irq_interval; it is
// always ready; the user must see that it is written only while the core
// is idle, as the core itself does not enforce this. An item passes
// capture, register file read and execute before its result is registered;
// one item is in flight at a time, and the controller passes a post-commit
// state before it accepts the next. MULT/DIV items (not a divide by zero)
// hold off the next item while the bit-serial multiply/divide unit runs; a
// delay-slot item of a taken branch that hits the interrupt check interval
// runs the same unit again to fold the instruction count back into range.
// A finished result waits in the output register when out_stall is high;
// the next item is accepted meanwhile but not committed until it drains.
// Reset (synchronous, rst high) zeroes the register file, HI/LO and the
// instruction count, and sets the PC to the boot vector.
module mips1_integer_execute_core #(
  parameter int COP0_REGS = mic_pkg::COP0_REGS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [31:0] instr_word,
  input  logic [31:0] load_data,
  input  logic        irq_pending,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] fetch_addr,
  output logic [1:0]  mem_op,
  output logic [31:0] mem_addr,
  output logic [3:0]  byte_enable,
  output logic [31:0] store_data,
  output logic        awaiting_load,
  output logic        exception_taken,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import mic_pkg::*;

  mic_cmd_t  cmd;
  mic_stat_t st;

  assign cfg_ready = 1'b1;

  mic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .st       (st)
  );

  mic_dp #(
    .COP0_REGS(COP0_REGS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .mode           (mode),
    .instr_word     (instr_word),
    .load_data      (load_data),
    .irq_pending    (irq_pending),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .fetch_addr     (fetch_addr),
    .mem_op         (mem_op),
    .mem_addr       (mem_addr),
    .byte_enable    (byte_enable),
    .store_data     (store_data),
    .awaiting_load  (awaiting_load),
    .exception_taken(exception_taken)
  );

endmodule
